### rtl/ics_pkg.sv
// Package for the integer 3x3 Cramer solver.
// Holds sequencer state type and output width constant; no dependencies.
package ics_pkg;
   localparam int OUT_BITS = 26;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_SIGN,
      ST_GCD_INIT,
      ST_GCD,
      ST_DIV_INIT,
      ST_DIV,
      ST_DIV_NEXT,
      ST_OUT
   } state_type;
endpackage

### rtl/ics_if.sv
// Valid/ready channel interface carrying a payload struct.
// Depends on nothing; payload type is a type parameter.
interface ics_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### rtl/integer_cramer_3x3_solver.sv
// Top level of the integer 3x3 Cramer solver.
// Depends on ics_pkg and ics_if.
//
// channel   dir  payload
// req       in   goal_part1..3, feed1..3_part1..3 (VALUE_BITS each)
// rsp       out  no_solution, amount_feed1..3, goal_multiple (26 bits)
//
// One transaction at a time. Every product goes through one shared
// signed multiplier for the four determinants; when a solution exists a
// subtractive-binary gcd over three pairs and four bit-serial divisions
// follow. req.ready is high only in idle; the result is held in an
// output register until rsp.ready, then idle again.
// Reset is synchronous and clears the sequencer and valid.
module integer_cramer_3x3_solver #(
   parameter int VALUE_BITS = 8
) (
   input logic clock,
   input logic reset,
   ics_if.sink   req,
   ics_if.source rsp
);
   import ics_pkg::*;

   // determinant magnitude bound: 6 * (2^V)^3 < 2^(3V+3)
   localparam int DW  = 3 * VALUE_BITS + 4;   // signed det width
   localparam int PW  = 2 * VALUE_BITS + 3;   // signed 2x2 minor width
   localparam int MW  = DW + PW;             // multiplier product width
   localparam int CW  = $clog2(DW + 1);

   // input values, index 0..11 as p,q,r,a,b,c,d,e,f,g,h,i
   logic [VALUE_BITS-1:0] val_ff [12];
   logic signed [DW-1:0]  det_ff [4];
   logic signed [DW-1:0]  acc_ff;
   logic signed [PW-1:0]  minor_ff;
   logic [3:0]            step_ff;
   logic [1:0]            dsel_ff;
   state_type             state_ff, state_in;
   logic [DW-1:0]         ga_ff, gb_ff;
   logic [CW-1:0]         shift_ff;
   logic [1:0]            gidx_ff;
   logic [DW-1:0]         gcd_ff;
   logic [DW-1:0]         quo_ff, rem_ff, num_ff;
   logic [CW-1:0]         bit_ff;
   logic [1:0]            qidx_ff;
   logic [OUT_BITS-1:0]   res_ff [4];
   logic                  nosol_ff;
   logic                  valid_ff;

   // column select: for det k > 0, col k-1 of the matrix is replaced by goal
   function automatic logic [3:0] elem_idx(input logic [1:0] dk,
                                           input logic [1:0] row,
                                           input logic [1:0] col);
      logic [3:0] idx;
      if (dk != 2'd0 && col == dk - 2'd1) idx = {2'd0, row};
      else idx = 4'd3 + 4'd3 * {2'd0, col} + {2'd0, row};
      return idx;
   endfunction

   // Sequencer step decode: 3 terms, each: 2 minor products then 1 outer.
   // step t: term=t/3, sub=t%3. minor of term j uses rows 1,2 and the two
   // columns other than j. sub0: m[1][c1]*m[2][c2]; sub1: subtract
   // m[1][c2]*m[2][c1]; sub2: acc +/- m[0][j]*minor.
   logic [1:0] term, sub, c1, c2;
   logic signed [DW:0]  mul_a;
   logic signed [PW:0]  mul_b;
   logic signed [MW+1:0] product;
   always_comb begin
      term = (step_ff >= 4'd6) ? 2'd2 : (step_ff >= 4'd3) ? 2'd1 : 2'd0;
      sub  = 2'(step_ff - 4'd3 * {2'd0, term});
      c1   = (term == 2'd0) ? 2'd1 : 2'd0;
      c2   = (term == 2'd2) ? 2'd1 : 2'd2;
      unique case (sub)
         2'd0: begin
            mul_a = (DW+1)'(val_ff[elem_idx(dsel_ff, 2'd1, c1)]);
            mul_b = (PW+1)'(val_ff[elem_idx(dsel_ff, 2'd2, c2)]);
         end
         2'd1: begin
            mul_a = (DW+1)'(val_ff[elem_idx(dsel_ff, 2'd1, c2)]);
            mul_b = (PW+1)'(val_ff[elem_idx(dsel_ff, 2'd2, c1)]);
         end
         default: begin
            mul_a = (DW+1)'(val_ff[elem_idx(dsel_ff, 2'd0, term)]);
            mul_b = (PW+1)'(minor_ff);
         end
      endcase
      product = (MW+2)'(mul_a) * (MW+2)'(mul_b);
   end

   // gcd helpers and sign check of the amounts
   logic [DW-1:0] det_mag;
   logic          det_neg;
   logic          amt_neg;
   logic [DW-1:0] gdiff;
   always_comb begin
      det_neg = det_ff[0][DW-1];
      det_mag = det_neg ? DW'(-det_ff[0]) : DW'(det_ff[0]);
      gdiff   = (ga_ff > gb_ff) ? ga_ff - gb_ff : gb_ff - ga_ff;
      // an amount is negative when Dk is nonzero with a sign unlike det
      amt_neg = 1'b0;
      for (int k = 1; k < 4; k++) begin
         if (det_ff[k] != '0 && det_ff[k][DW-1] != det_neg) amt_neg = 1'b1;
      end
   end

   // bit-serial restoring division step
   logic [DW:0] trial;
   always_comb trial = {rem_ff, num_ff[DW-1]} - {1'b0, gcd_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req.valid) state_in = ST_MUL;
         ST_MUL: if (step_ff == 4'd8 && dsel_ff == 2'd3) state_in = ST_SIGN;
         ST_SIGN: begin
            if (det_ff[0] == '0 || amt_neg) state_in = ST_OUT;
            else state_in = ST_GCD_INIT;
         end
         ST_GCD_INIT: state_in = ST_GCD;
         ST_GCD: begin
            if (gb_ff == '0 || ga_ff == '0) begin
               if (gidx_ff == 2'd3) state_in = ST_DIV_INIT;
               else state_in = ST_GCD_INIT;
            end
         end
         ST_DIV_INIT: state_in = ST_DIV;
         ST_DIV: if (bit_ff == CW'(DW - 1)) state_in = ST_DIV_NEXT;
         ST_DIV_NEXT: if (qidx_ff == 2'd3) state_in = ST_OUT;
                      else state_in = ST_DIV_INIT;
         ST_OUT: if (rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req.ready = (state_ff == ST_IDLE);
      rsp.valid = valid_ff;
      rsp.data.no_solution   = nosol_ff;
      rsp.data.amount_feed1  = res_ff[0];
      rsp.data.amount_feed2  = res_ff[1];
      rsp.data.amount_feed3  = res_ff[2];
      rsp.data.goal_multiple = res_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
      if (reset) valid_ff <= 1'b0;
      else if (state_ff == ST_OUT && rsp.ready) valid_ff <= 1'b0;
      else if (state_in == ST_OUT && state_ff != ST_OUT) valid_ff <= 1'b1;
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            val_ff[0]  <= req.data.goal_part1[VALUE_BITS-1:0];
            val_ff[1]  <= req.data.goal_part2[VALUE_BITS-1:0];
            val_ff[2]  <= req.data.goal_part3[VALUE_BITS-1:0];
            val_ff[3]  <= req.data.feed1_part1[VALUE_BITS-1:0];
            val_ff[4]  <= req.data.feed1_part2[VALUE_BITS-1:0];
            val_ff[5]  <= req.data.feed1_part3[VALUE_BITS-1:0];
            val_ff[6]  <= req.data.feed2_part1[VALUE_BITS-1:0];
            val_ff[7]  <= req.data.feed2_part2[VALUE_BITS-1:0];
            val_ff[8]  <= req.data.feed2_part3[VALUE_BITS-1:0];
            val_ff[9]  <= req.data.feed3_part1[VALUE_BITS-1:0];
            val_ff[10] <= req.data.feed3_part2[VALUE_BITS-1:0];
            val_ff[11] <= req.data.feed3_part3[VALUE_BITS-1:0];
            step_ff  <= '0;
            dsel_ff  <= '0;
            acc_ff   <= '0;
            nosol_ff <= 1'b0;
         end
         ST_MUL: begin
            unique case (sub)
               2'd0: minor_ff <= PW'(product);
               2'd1: minor_ff <= minor_ff - PW'(product);
               default: begin
                  if (step_ff == 4'd8) acc_ff <= '0;
                  else if (term == 2'd1) acc_ff <= acc_ff - DW'(product);
                  else acc_ff <= acc_ff + DW'(product);
               end
            endcase
            if (step_ff == 4'd8) begin
               step_ff <= '0;
               det_ff[dsel_ff] <= (term == 2'd1) ? acc_ff - DW'(product)
                                                 : acc_ff + DW'(product);
               dsel_ff <= dsel_ff + 2'd1;
            end else begin
               step_ff <= step_ff + 4'd1;
            end
         end
         ST_SIGN: begin
            // negate the Dk when det is negative, so their signs go with |det|
            for (int k = 1; k < 4; k++) begin
               if (det_neg) det_ff[k] <= -det_ff[k];
            end
            if (amt_neg || det_ff[0] == '0) nosol_ff <= 1'b1;
            gcd_ff  <= det_mag;
            gidx_ff <= 2'd0;
            for (int k = 0; k < 4; k++) res_ff[k] <= '0;
         end
         ST_GCD_INIT: begin
            ga_ff    <= gcd_ff;
            gb_ff    <= DW'(det_ff[gidx_ff + 2'd1]);
            gidx_ff  <= gidx_ff + 2'd1;
         end
         ST_GCD: begin
            // Euclid by subtraction with halving of even operands
            if (gb_ff == '0 || ga_ff == '0)
               gcd_ff <= ((gb_ff == '0) ? ga_ff : gb_ff) << shift_ff;
            else if (!ga_ff[0] && !gb_ff[0]) begin
               ga_ff <= ga_ff >> 1;
               gb_ff <= gb_ff >> 1;
               shift_ff <= shift_ff + CW'(1);
            end else if (!ga_ff[0]) ga_ff <= ga_ff >> 1;
            else if (!gb_ff[0]) gb_ff <= gb_ff >> 1;
            else if (ga_ff > gb_ff) ga_ff <= gdiff;
            else gb_ff <= gdiff;
            qidx_ff <= 2'd0;
         end
         ST_DIV_INIT: begin
            num_ff <= (qidx_ff == 2'd3) ? det_mag : DW'(det_ff[qidx_ff + 2'd1]);
            rem_ff <= '0;
            quo_ff <= '0;
            bit_ff <= '0;
         end
         ST_DIV: begin
            if (!trial[DW]) begin
               rem_ff <= trial[DW-1:0];
               quo_ff <= {quo_ff[DW-2:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[DW-2:0], num_ff[DW-1]};
               quo_ff <= {quo_ff[DW-2:0], 1'b0};
            end
            num_ff <= num_ff << 1;
            bit_ff <= bit_ff + CW'(1);
         end
         ST_DIV_NEXT: begin
            res_ff[qidx_ff] <= OUT_BITS'(quo_ff);
            qidx_ff <= qidx_ff + 2'd1;
         end
         default: ;
      endcase
      if (state_ff == ST_GCD_INIT) shift_ff <= '0;
   end

`ifndef SYNTHESIS
   // a result is offered only after computation finished
   a_valid_out: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> state_ff == ST_OUT) else $error("rsp valid outside output");
   // no new request while a result is pending
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("ready while result pending");
   // no-solution results carry a zero goal multiple
   a_nosol_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.data.no_solution) |-> rsp.data.goal_multiple == '0)
      else $error("nonzero multiple with no solution");
`endif
endmodule

### verif/ics_tb_pkg.sv
// Transaction types shared by the solver testbench and its checker.
// Depends on ics_pkg for the output width.
package ics_tb_pkg;
   import ics_pkg::*;

   localparam int VALUE_BITS = 8;

   // one request transaction: the goal vector and three feed vectors
   typedef struct packed {
      logic [VALUE_BITS-1:0] goal_part1;
      logic [VALUE_BITS-1:0] goal_part2;
      logic [VALUE_BITS-1:0] goal_part3;
      logic [VALUE_BITS-1:0] feed1_part1;
      logic [VALUE_BITS-1:0] feed1_part2;
      logic [VALUE_BITS-1:0] feed1_part3;
      logic [VALUE_BITS-1:0] feed2_part1;
      logic [VALUE_BITS-1:0] feed2_part2;
      logic [VALUE_BITS-1:0] feed2_part3;
      logic [VALUE_BITS-1:0] feed3_part1;
      logic [VALUE_BITS-1:0] feed3_part2;
      logic [VALUE_BITS-1:0] feed3_part3;
   } mix_request_type;

   // one response transaction: the whole-unit recipe
   typedef struct packed {
      logic                no_solution;
      logic [OUT_BITS-1:0] amount_feed1;
      logic [OUT_BITS-1:0] amount_feed2;
      logic [OUT_BITS-1:0] amount_feed3;
      logic [OUT_BITS-1:0] goal_multiple;
   } mix_recipe_type;
endpackage

### verif/ics_recipe_checker.sv
// Checker for the integer Cramer solver: watches both channels, predicts
// each recipe with exact integer arithmetic and compares. Depends on ics_pkg and ics_tb_pkg.
module ics_recipe_checker (
   input  logic clock,
   input  logic reset,
   ics_if       req_mon,
   ics_if       rsp_mon,
   output int   mismatch_count,
   output int   recipes_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import ics_pkg::*, ics_tb_pkg::*;

   mix_recipe_type recipe_queue[$];

   function automatic longint det3(longint m11, longint m12, longint m13,
                                   longint m21, longint m22, longint m23,
                                   longint m31, longint m32, longint m33);
      return m11 * (m22 * m33 - m23 * m32) - m12 * (m21 * m33 - m23 * m31)
           + m13 * (m21 * m32 - m22 * m31);
   endfunction

   function automatic longint gcd_of(longint u, longint v);
      longint t;
      while (v != 0) begin
         t = u % v;
         u = v;
         v = t;
      end
      return u;
   endfunction

   // feeds are the matrix columns; goal replaces one column per numerator
   function automatic mix_recipe_type solve_recipe(mix_request_type t);
      mix_recipe_type r;
      longint p, q, s, a, b, c, d, e, f, g, h, i;
      longint dm, den, gg;
      longint dk[3];
      p = t.goal_part1;  q = t.goal_part2;  s = t.goal_part3;
      a = t.feed1_part1; b = t.feed1_part2; c = t.feed1_part3;
      d = t.feed2_part1; e = t.feed2_part2; f = t.feed2_part3;
      g = t.feed3_part1; h = t.feed3_part2; i = t.feed3_part3;
      r = '0;
      r.no_solution = 1'b1;
      dm = det3(a, d, g, b, e, h, c, f, i);
      dk[0] = det3(p, d, g, q, e, h, s, f, i);
      dk[1] = det3(a, p, g, b, q, h, c, s, i);
      dk[2] = det3(a, d, p, b, e, q, c, f, s);
      // singular system
      if (dm == 0) return r;
      for (int k = 0; k < 3; k++) begin
         if (dm < 0) dk[k] = -dk[k];
         // a negative amount means no mix exists
         if (dk[k] < 0) return r;
      end
      den = (dm < 0) ? -dm : dm;
      gg = den;
      for (int k = 0; k < 3; k++) gg = gcd_of(gg, dk[k]);
      r.no_solution   = 1'b0;
      r.amount_feed1  = OUT_BITS'(dk[0] / gg);
      r.amount_feed2  = OUT_BITS'(dk[1] / gg);
      r.amount_feed3  = OUT_BITS'(dk[2] / gg);
      r.goal_multiple = OUT_BITS'(den / gg);
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("%0t: recipe %s got %0d expected %0d", $realtime, field, got, want);
      mismatch_count++;
   endtask

   initial begin
      mismatch_count  = 0;
      recipes_pending = 0;
   end

   // predict on request, compare on response
   always @(posedge clock) begin
      mix_recipe_type got, want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            recipe_queue.push_back(solve_recipe(req_mon.data));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.data;
            if (recipe_queue.size() == 0) begin
               $display("%0t: recipe transaction with none outstanding", $realtime);
               mismatch_count++;
            end else begin
               want = recipe_queue.pop_front();
               if (got.no_solution !== want.no_solution)
                  report_mismatch("no_solution", got.no_solution, want.no_solution);
               if (got.amount_feed1 !== want.amount_feed1)
                  report_mismatch("amount_feed1", got.amount_feed1, want.amount_feed1);
               if (got.amount_feed2 !== want.amount_feed2)
                  report_mismatch("amount_feed2", got.amount_feed2, want.amount_feed2);
               if (got.amount_feed3 !== want.amount_feed3)
                  report_mismatch("amount_feed3", got.amount_feed3, want.amount_feed3);
               if (got.goal_multiple !== want.goal_multiple)
                  report_mismatch("goal_multiple", got.goal_multiple, want.goal_multiple);
            end
         end
         recipes_pending = recipe_queue.size();
      end
   end
endmodule

### verif/tb_integer_cramer_3x3_solver.sv
// Top of the integer Cramer solver testbench: clock, reset, request and
// response traffic, verdict. Depends on ics_pkg, ics_if, ics_tb_pkg, checker, solver.
module tb_integer_cramer_3x3_solver;
   timeunit 1ns;
   timeprecision 1ps;
   import ics_pkg::*, ics_tb_pkg::*;

   localparam int RANDOM_ITEMS = 1530;
   localparam int CALM_ITEMS   = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatch_count, recipes_pending;
   bit   rsp_calm = 1'b0;
   bit   rsp_hold = 1'b0;

   ics_if #(.payload_type(mix_request_type)) req (clock);
   ics_if #(.payload_type(mix_recipe_type))  rsp (clock);

   integer_cramer_3x3_solver #(.VALUE_BITS(VALUE_BITS)) uut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp)
   );

   ics_recipe_checker checker_i (
      .clock(clock), .reset(reset), .req_mon(req), .rsp_mon(rsp),
      .mismatch_count(mismatch_count), .recipes_pending(recipes_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #30ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic mix_request_type mix(int p, int q, int s, int a, int b, int c,
                                           int d, int e, int f, int g, int h, int i);
      mix_request_type t;
      t = {8'(p), 8'(q), 8'(s), 8'(a), 8'(b), 8'(c),
           8'(d), 8'(e), 8'(f), 8'(g), 8'(h), 8'(i)};
      return t;
   endfunction

   // up to half the goals built from whole amounts of the feeds, plus noise
   function automatic mix_request_type random_request();
      mix_request_type t;
      int sel, lim, x, y, z;
      int fv[9];
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
         t = {$urandom, $urandom, $urandom};
      end else if (sel < 9) begin
         lim = (sel == 8) ? 255 : $urandom_range(3, 80);
         foreach (fv[k]) fv[k] = $urandom_range(0, lim);
         x = $urandom_range(0, 3);
         y = $urandom_range(0, 3);
         z = $urandom_range(0, 3);
         t = mix(x*fv[0] + y*fv[3] + z*fv[6], x*fv[1] + y*fv[4] + z*fv[7],
                 x*fv[2] + y*fv[5] + z*fv[8], fv[0], fv[1], fv[2],
                 fv[3], fv[4], fv[5], fv[6], fv[7], fv[8]);
         // keep it a legal goal; overflow turns it into plain noise
         if (x*fv[0] + y*fv[3] + z*fv[6] > 255 || x*fv[1] + y*fv[4] + z*fv[7] > 255
             || x*fv[2] + y*fv[5] + z*fv[8] > 255)
            t.goal_part1 = 8'($urandom);
      end else begin
         for (int k = 0; k < 12; k++) t[k*8 +: 8] = 8'($urandom_range(0, 3));
      end
      return t;
   endfunction

   task automatic send_request(mix_request_type t, bit may_idle);
      int gap;
      if (may_idle && !rsp_calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data  <= t;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic drop_valid_and_drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (recipes_pending != 0) @(posedge clock);
   endtask

   // response side: random stall bursts, one long hold on request
   initial begin
      int stall, hold;
      bit held;
      rsp.ready <= 1'b0;
      stall = 0;
      hold  = 0;
      held  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold && !held) begin
            hold = 1000;
            held = 1'b1;
         end
         if (hold > 0) begin
            hold--;
            rsp.ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp.ready <= 1'b0;
         end else if (!rsp_calm && $urandom_range(0, 4) == 0) begin
            stall = $urandom_range(1, 7) - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // stimulus and verdict
   initial begin
      mix_request_type directed[$];
      int waited;
      req.valid <= 1'b0;
      req.data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed.push_back(mix(0,0,0, 0,0,0, 0,0,0, 0,0,0));           // singular, zeros
      directed.push_back(mix(255,255,255, 255,255,255, 255,255,255,
                             255,255,255));                          // singular, max
      directed.push_back(mix(0,0,0, 1,0,0, 0,1,0, 0,0,1));           // zero goal
      directed.push_back(mix(0,0,0, 0,1,0, 1,0,0, 0,0,1));           // zero goal, det<0
      directed.push_back(mix(7,9,11, 1,0,0, 0,1,0, 0,0,1));          // identity
      directed.push_back(mix(9,7,11, 0,1,0, 1,0,0, 0,0,1));          // negative det
      directed.push_back(mix(1,0,0, 2,0,0, 0,2,0, 0,0,2));           // fractional
      directed.push_back(mix(0,5,0, 1,0,0, 0,1,0, 0,0,1));
      directed.push_back(mix(1,1,1, 1,0,0, 0,1,0, 0,0,1));
      directed.push_back(mix(1,0,0, 1,1,0, 0,1,0, 0,0,1));           // negative amount
      directed.push_back(mix(1,0,0, 0,1,0, 1,1,0, 0,0,1));           // negative, det<0
      directed.push_back(mix(255,255,255, 255,0,0, 0,255,0, 0,0,255));
      directed.push_back(mix(255,0,0, 1,0,0, 0,255,0, 0,0,255));
      directed.push_back(mix(1,1,1, 255,0,0, 0,255,0, 0,0,254));     // big multiple
      directed.push_back(mix(0,0,0, 255,0,0, 0,0,255, 0,255,0));     // zero goal, det<0
      directed.push_back(mix(255,255,0, 255,0,255, 0,255,255,
                             255,255,255));                          // negative amount, det<0
      directed.push_back(mix(170,85,170, 85,170,85, 170,85,170,
                             85,170,85));
      directed.push_back(mix(200,100,50, 3,1,4, 1,5,9, 2,6,5));
      foreach (directed[k]) send_request(directed[k], 1'b1);

      // pause until the block has drained completely
      drop_valid_and_drain();

      // receiver holds off while requests keep coming
      rsp_hold <= 1'b1;
      for (int k = 0; k < 4; k++) send_request(random_request(), 1'b0);
      rsp_hold <= 1'b0;

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS - CALM_ITEMS) rsp_calm <= 1'b1;
         if (k == RANDOM_ITEMS / 2) drop_valid_and_drain();
         send_request(random_request(), 1'b1);
      end
      req.valid <= 1'b0;
      @(posedge clock);

      waited = 0;
      while (recipes_pending != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (500) @(posedge clock);
      if (mismatch_count == 0 && recipes_pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

### files.f
rtl/ics_pkg.sv
rtl/ics_if.sv
rtl/integer_cramer_3x3_solver.sv
verif/ics_tb_pkg.sv
verif/ics_recipe_checker.sv
verif/tb_integer_cramer_3x3_solver.sv
